FILE: design/rdc_pkg.sv
`timescale 1ns / 1ps
// Package for the radix digit converter: field widths, constants, sequencer
// states, the control struct of the term unit and the radix clamp function.
// No dependencies.
package rdc_pkg;

   // Bits of the incoming number that take part in the conversion.
   localparam int NUMBER_WIDTH = 64;

   localparam int IN_W     = 64;
   localparam int RADIX_W  = 7;
   localparam int DIGIT_W  = 6;
   localparam int CHAR_W   = 7;
   localparam int POS_W    = 6;
   localparam int TERM_W   = 64;
   localparam int PROD_W   = NUMBER_WIDTH + RADIX_W;
   localparam int DIV_CNT_W = (NUMBER_WIDTH > 1) ? $clog2(NUMBER_WIDTH) : 1;

   localparam logic [CHAR_W-1:0]  CHAR_OFFSET = 7'd48;
   localparam logic [RADIX_W-1:0] RADIX_RESET = 7'd10;
   localparam logic [RADIX_W-1:0] RADIX_MIN   = 7'd2;
   localparam logic [RADIX_W-1:0] RADIX_MAX   = 7'd64;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_TERM,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic init;   // load the place value with one
      logic step;   // form the term and advance the place value
   } term_ctrl_type;

   // Clamp the programmed radix into the supported range 2..64.
   function automatic logic [RADIX_W-1:0] effective_radix(input logic [RADIX_W-1:0] r);
      logic [RADIX_W-1:0] e;
      e = r;
      if (r < RADIX_MIN) begin
         e = RADIX_MIN;
      end else if (r > RADIX_MAX) begin
         e = RADIX_MAX;
      end
      return e;
   endfunction

endpackage

FILE: design/rdc_divider.sv
`timescale 1ns / 1ps
// Bit-serial restoring divider: one quotient bit per cycle, dividing the
// NUMBER_WIDTH-bit value by a radix of at most 64. Depends on rdc_pkg.
module rdc_divider
   import rdc_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic [NUMBER_WIDTH-1:0] dividend,
   input  logic [RADIX_W-1:0]      divisor,
   output logic                    done,
   output logic [NUMBER_WIDTH-1:0] quotient,
   output logic [DIGIT_W-1:0]      remainder
);

   logic                    busy_ff;
   logic                    done_ff;
   logic [DIV_CNT_W-1:0]    cnt_ff;
   logic [NUMBER_WIDTH-1:0] quot_ff;
   logic [DIGIT_W-1:0]      rem_ff;
   logic [RADIX_W-1:0]      div_ff;

   logic [RADIX_W-1:0]      trial;
   logic                    fits;
   logic [RADIX_W-1:0]      diff;

   // The partial remainder stays below the divisor, so it fits six bits and
   // the shifted trial value fits seven.
   assign trial = {rem_ff, quot_ff[NUMBER_WIDTH-1]};
   assign fits  = (trial >= div_ff);
   assign diff  = trial - div_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= DIV_CNT_W'(NUMBER_WIDTH - 1);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         quot_ff <= dividend;
         rem_ff  <= '0;
         div_ff  <= divisor;
      end else if (busy_ff) begin
         quot_ff <= {quot_ff[NUMBER_WIDTH-2:0], fits};
         rem_ff  <= fits ? diff[DIGIT_W-1:0] : trial[DIGIT_W-1:0];
      end
   end

   assign done      = done_ff;
   assign quotient  = quot_ff;
   assign remainder = rem_ff;

endmodule

FILE: design/rdc_term_unit.sv
`timescale 1ns / 1ps
// Place value register and the two products of one digit: the term
// digit * place and the next place value place * radix. Depends on rdc_pkg.
module rdc_term_unit
   import rdc_pkg::*;
(
   input  logic                clock,
   input  term_ctrl_type       ctrl,
   input  logic [DIGIT_W-1:0]  digit,
   input  logic [RADIX_W-1:0]  radix,
   output logic [TERM_W-1:0]   term
);

   logic [NUMBER_WIDTH-1:0] place_ff;
   logic [NUMBER_WIDTH-1:0] place_in;
   logic [NUMBER_WIDTH-1:0] term_ff;
   logic [NUMBER_WIDTH-1:0] term_in;
   logic [PROD_W-1:0]       term_prod;
   logic [PROD_W-1:0]       place_prod;

   // The term never exceeds the number itself, so truncation loses nothing.
   // The advanced place value may wrap after the top digit, where it is unused.
   assign term_prod  = PROD_W'(place_ff) * PROD_W'(digit);
   assign place_prod = PROD_W'(place_ff) * PROD_W'(radix);
   assign term_in    = term_prod[NUMBER_WIDTH-1:0];
   assign place_in   = place_prod[NUMBER_WIDTH-1:0];

   always_ff @(posedge clock) begin
      if (ctrl.init) begin
         place_ff <= NUMBER_WIDTH'(1);
      end else if (ctrl.step) begin
         place_ff <= place_in;
         term_ff  <= term_in;
      end
   end

   assign term = TERM_W'(term_ff);

endmodule

FILE: design/radix_digit_converter.sv
`timescale 1ns / 1ps
// Top level of the radix digit converter: request and response channels,
// the radix register and the digit sequencer. Depends on rdc_pkg,
// rdc_divider and rdc_term_unit.
//
//   channel   direction  handshake           payload
//   req_      in         req_valid/stall     req_number
//   rsp_      out        rsp_valid/stall     digit_value, digit_char,
//                                            position, term, last
//   csr_      in         csr_valid/ready     csr_radix
//
// Each digit passes through these steps, plus any response stall: the
// divider is loaded, the bit-serial divider runs (one quotient bit per
// cycle), the result is handed over to the digit registers and the term
// multiply is done; the response is then held until taken. A number with
// n digits thus passes through these steps n times.
// Reset is synchronous and active high; it returns the radix to ten and
// the sequencer to idle. req_stall stays high from the accepted request
// until its most significant digit has been taken.
module radix_digit_converter
   import rdc_pkg::*;
(
   input  logic                clock,
   input  logic                reset,

   input  logic                req_valid,
   output logic                req_stall,
   input  logic [IN_W-1:0]     req_number,

   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [DIGIT_W-1:0]  rsp_digit_value,
   output logic [CHAR_W-1:0]   rsp_digit_char,
   output logic [POS_W-1:0]    rsp_position,
   output logic [TERM_W-1:0]   rsp_term,
   output logic                rsp_last,

   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [RADIX_W-1:0]  csr_radix
);

   state_type               state_ff;
   state_type               state_in;

   logic [RADIX_W-1:0]      radix_ff;
   logic [RADIX_W-1:0]      base_ff;
   logic [NUMBER_WIDTH-1:0] rest_ff;
   logic [DIGIT_W-1:0]      digit_ff;
   logic [POS_W-1:0]        pos_ff;

   logic                    req_accept;
   logic                    rsp_accept;
   logic                    rest_zero;
   logic                    div_start;
   logic [NUMBER_WIDTH-1:0] div_operand;
   logic                    div_done;
   logic [NUMBER_WIDTH-1:0] div_quot;
   logic [DIGIT_W-1:0]      div_rem;
   term_ctrl_type           term_ctrl;
   logic [TERM_W-1:0]       term_value;

   // The radix register may be written at any time; writes are only
   // expected while no conversion is under way.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         radix_ff <= RADIX_RESET;
      end else if (csr_valid && csr_ready) begin
         radix_ff <= csr_radix;
      end
   end

   assign req_stall  = (state_ff != ST_IDLE);
   assign rsp_valid  = (state_ff == ST_EMIT);
   assign req_accept = req_valid && !req_stall;
   assign rsp_accept = rsp_valid && !rsp_stall;
   assign rest_zero  = (rest_ff == '0);

   // Sequencer: divide, form the term, offer the digit, and repeat on the
   // quotient until it reaches zero.
   always_comb begin
      state_in         = state_ff;
      div_start        = 1'b0;
      div_operand      = rest_ff;
      term_ctrl.init   = 1'b0;
      term_ctrl.step   = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               div_start      = 1'b1;
               div_operand    = req_number[NUMBER_WIDTH-1:0];
               term_ctrl.init = 1'b1;
               state_in       = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            if (div_done) begin
               state_in = ST_TERM;
            end
         end
         ST_TERM: begin
            term_ctrl.step = 1'b1;
            state_in       = ST_EMIT;
         end
         ST_EMIT: begin
            if (rsp_accept) begin
               if (rest_zero) begin
                  state_in = ST_IDLE;
               end else begin
                  div_start = 1'b1;
                  state_in  = ST_DIVIDE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Datapath registers of the current number.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         base_ff <= effective_radix(radix_ff);
         pos_ff  <= '0;
      end else if (rsp_accept && !rest_zero) begin
         pos_ff  <= pos_ff + 1'b1;
      end
      if (state_ff == ST_DIVIDE && div_done) begin
         rest_ff  <= div_quot;
         digit_ff <= div_rem;
      end
   end

   rdc_divider u_divider (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_operand),
      .divisor   (req_accept ? effective_radix(radix_ff) : base_ff),
      .done      (div_done),
      .quotient  (div_quot),
      .remainder (div_rem)
   );

   rdc_term_unit u_term (
      .clock (clock),
      .ctrl  (term_ctrl),
      .digit (digit_ff),
      .radix (base_ff),
      .term  (term_value)
   );

   // All response fields come from registers that hold still while the
   // sequencer waits in the emit state.
   assign rsp_digit_value = digit_ff;
   assign rsp_digit_char  = CHAR_W'(digit_ff) + CHAR_OFFSET;
   assign rsp_position    = pos_ff;
   assign rsp_term        = term_value;
   assign rsp_last        = rest_zero;

endmodule
